### src/tspg_pkg.sv
// tspg_pkg: request and result types and constants for the three-axis step pulse generator
// no dependencies; used by tspg_axis and three_axis_step_pulse_generator_top
package tspg_pkg;

  localparam logic [1:0] ACT_STEP = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_BEEP = 2'd2;

  localparam logic REG_DRIVE_ENABLED = 1'b0;

  localparam logic [7:0] IDLE_BYTE = 8'b0000_0001;
  localparam logic [7:0] ZERO_BYTE = 8'b0000_0000;

  typedef struct packed {
    logic        [1:0]  action;
    logic signed [31:0] steps_x;
    logic signed [31:0] steps_y;
    logic signed [31:0] steps_z;
    logic        [15:0] beep_duration_ms;
    logic        [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        [7:0]  pulse_byte;
    logic               was_idle;
    logic signed [31:0] position_x_out;
    logic signed [31:0] position_y_out;
    logic signed [31:0] position_z_out;
  } res_t;

  typedef struct packed {
    logic step;
    logic dir;
  } axis_bits_t;

endpackage

### src/tspg_axis.sv
// tspg_axis: one stepper axis, moves pending toward zero and tracks the wrapping position
// depends on tspg_pkg
module tspg_axis (
  input  logic               en,
  input  logic signed [31:0] pending,
  input  logic signed [31:0] position,
  output logic signed [31:0] pending_next,
  output logic signed [31:0] position_next,
  output tspg_pkg::axis_bits_t bits
);

  logic busy;

  assign busy = en && (pending != 32'sd0);

  always_comb begin
    pending_next  = pending;
    position_next = position;
    bits.step     = 1'b0;
    bits.dir      = 1'b0;
    if (busy) begin
      bits.step = 1'b1;
      if (!pending[31]) begin
        bits.dir      = 1'b1;
        pending_next  = pending - 32'sd1;
        position_next = position + 32'sd1;
      end else begin
        pending_next  = pending + 32'sd1;
        position_next = position - 32'sd1;
      end
    end
  end

endmodule

### src/three_axis_step_pulse_generator_top.sv
// three_axis_step_pulse_generator_top: request register, step/beep logic, result register
// depends on tspg_pkg and tspg_axis
// The block takes one request per clock while req_stall is low and returns one result per
// request: each request passes through the request register, where the step, load and beep
// logic reads the axis state, and then the result register, which holds a result while the
// receiver stalls and lets the next request enter behind it. Throughput is one request per
// clock whenever res_stall is low. The drive_enabled register sits at byte address 0 of the
// configuration port and should only be written while no request is in flight.
module three_axis_step_pulse_generator_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  tspg_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_stall,
  output tspg_pkg::res_t  res,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic               drive_enabled;
  logic signed [31:0] pending_x, pending_y, pending_z;
  logic signed [31:0] position_x, position_y, position_z;
  logic        [15:0] beep_left;
  logic        [31:0] period_start;

  logic               stage_valid;
  tspg_pkg::req_t     stage;

  logic               advance;
  logic               is_step;
  logic               idle;
  logic               step_en;
  logic        [31:0] elapsed;
  logic        [15:0] beep_step;

  logic signed [31:0] pending_x_next, pending_y_next, pending_z_next;
  logic signed [31:0] position_x_next, position_y_next, position_z_next;
  logic signed [31:0] ax_pend_x, ax_pend_y, ax_pend_z;
  logic signed [31:0] ax_pos_x, ax_pos_y, ax_pos_z;
  logic        [15:0] beep_left_next;
  logic        [31:0] period_start_next;
  tspg_pkg::axis_bits_t bits_x, bits_y, bits_z;
  tspg_pkg::res_t     res_next;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tspg_pkg::REG_DRIVE_ENABLED) ? {31'd0, drive_enabled} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_enabled <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == tspg_pkg::REG_DRIVE_ENABLED) begin
      drive_enabled <= pwdata[0];
    end
  end

  // pipeline control
  assign advance   = stage_valid && (!res_valid || !res_stall);
  assign req_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      stage <= req;
    end
  end

  // step cycle decisions
  assign is_step = (stage.action == tspg_pkg::ACT_STEP);
  assign idle    = (!drive_enabled && beep_left == 16'd0) ||
                   (pending_x == 32'sd0 && pending_y == 32'sd0 && pending_z == 32'sd0);
  assign step_en = is_step && !idle && drive_enabled;
  assign elapsed = stage.now_ms - period_start;
  assign beep_step = (elapsed > {16'd0, beep_left}) ? 16'd0 : beep_left;

  tspg_axis u_axis_x (
    .en(step_en), .pending(pending_x), .position(position_x),
    .pending_next(ax_pend_x), .position_next(ax_pos_x), .bits(bits_x)
  );

  tspg_axis u_axis_y (
    .en(step_en), .pending(pending_y), .position(position_y),
    .pending_next(ax_pend_y), .position_next(ax_pos_y), .bits(bits_y)
  );

  tspg_axis u_axis_z (
    .en(step_en), .pending(pending_z), .position(position_z),
    .pending_next(ax_pend_z), .position_next(ax_pos_z), .bits(bits_z)
  );

  always_comb begin
    pending_x_next    = pending_x;
    pending_y_next    = pending_y;
    pending_z_next    = pending_z;
    position_x_next   = ax_pos_x;
    position_y_next   = ax_pos_y;
    position_z_next   = ax_pos_z;
    beep_left_next    = beep_left;
    period_start_next = period_start;
    res_next.pulse_byte = tspg_pkg::ZERO_BYTE;
    res_next.was_idle   = 1'b0;
    case (stage.action)
      tspg_pkg::ACT_STEP: begin
        if (idle) begin
          res_next.pulse_byte = tspg_pkg::IDLE_BYTE;
          res_next.was_idle   = 1'b1;
          period_start_next   = stage.now_ms;
        end else begin
          pending_x_next = ax_pend_x;
          pending_y_next = ax_pend_y;
          pending_z_next = ax_pend_z;
          beep_left_next = beep_step;
          res_next.pulse_byte = {beep_step != 16'd0,
                                 bits_z.dir, bits_z.step,
                                 bits_y.dir, bits_y.step,
                                 bits_x.dir, bits_x.step,
                                 !drive_enabled};
        end
      end
      tspg_pkg::ACT_LOAD: begin
        pending_x_next = stage.steps_x;
        pending_y_next = stage.steps_y;
        pending_z_next = stage.steps_z;
      end
      tspg_pkg::ACT_BEEP: begin
        beep_left_next = stage.beep_duration_ms;
      end
      default: begin
      end
    endcase
    res_next.position_x_out = position_x_next;
    res_next.position_y_out = position_y_next;
    res_next.position_z_out = position_z_next;
  end

  // axis and beep state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_x    <= 32'sd0;
      pending_y    <= 32'sd0;
      pending_z    <= 32'sd0;
      position_x   <= 32'sd0;
      position_y   <= 32'sd0;
      position_z   <= 32'sd0;
      beep_left    <= 16'd0;
      period_start <= 32'd0;
    end else if (advance) begin
      pending_x    <= pending_x_next;
      pending_y    <= pending_y_next;
      pending_z    <= pending_z_next;
      position_x   <= position_x_next;
      position_y   <= position_y_next;
      position_z   <= position_z_next;
      beep_left    <= beep_left_next;
      period_start <= period_start_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule
